@@ sv/aes_pkg.sv @@
// Package: AES constants, tables, register indexes and round functions.
`timescale 1ns / 1ps
package aes_pkg;

  typedef logic [7:0] byte_tbl_t [256];
  typedef logic [7:0] blk_bytes_t [16];

  typedef enum logic [2:0] {
    REG_KEY_LEN = 3'd0,
    REG_KEY_W0  = 3'd1,
    REG_KEY_W1  = 3'd2,
    REG_KEY_W2  = 3'd3,
    REG_KEY_W3  = 3'd4
  } reg_idx_t;

  typedef enum logic {
    KX_IDLE,
    KX_RUN
  } kx_state_t;

  localparam int NumStages = 15;  // initial key add plus 14 round stages
  localparam int RkWords   = 60;
  localparam logic [7:0] GfPoly = 8'h1b;

  localparam byte_tbl_t SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Inverse S-box, built at elaboration from the forward table
  function automatic byte_tbl_t mk_inv_sbox();
    byte_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[SBOX[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam byte_tbl_t INV_SBOX = mk_inv_sbox();

  function automatic logic [7:0] xt(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Byte i of the block sits at bits [127-8i -: 8]
  function automatic blk_bytes_t unpack(logic [127:0] s);
    blk_bytes_t b;
    for (int i = 0; i < 16; i++) begin
      b[i] = s[127-8*i -: 8];
    end
    return b;
  endfunction

  function automatic logic [127:0] pack(blk_bytes_t b);
    logic [127:0] s;
    for (int i = 0; i < 16; i++) begin
      s[127-8*i -: 8] = b[i];
    end
    return s;
  endfunction

  // Forward round: SubBytes, ShiftRows, MixColumns (not on last), AddRoundKey
  function automatic logic [127:0] enc_round(logic [127:0] s, logic [127:0] k, logic last);
    blk_bytes_t a, t, o;
    logic [7:0] a0, a1, a2, a3;
    a = unpack(s);
    for (int i = 0; i < 16; i++) begin
      t[i] = SBOX[a[i]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[r + 4*c] = t[r + 4*((c + r) % 4)];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = o[4*c]; a1 = o[4*c+1]; a2 = o[4*c+2]; a3 = o[4*c+3];
        o[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        o[4*c+1] = xt(a1) ^ xt(a2) ^ a2 ^ a3 ^ a0;
        o[4*c+2] = xt(a2) ^ xt(a3) ^ a3 ^ a0 ^ a1;
        o[4*c+3] = xt(a3) ^ xt(a0) ^ a0 ^ a1 ^ a2;
      end
    end
    return pack(o) ^ k;
  endfunction

  // GF multiply by 9, 11, 13, 14 via doubling chain
  function automatic logic [7:0] gm9(logic [7:0] a);
    return xt(xt(xt(a))) ^ a;
  endfunction
  function automatic logic [7:0] gm11(logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(a) ^ a;
  endfunction
  function automatic logic [7:0] gm13(logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
  endfunction
  function automatic logic [7:0] gm14(logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
  endfunction

  // Inverse round: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns (not on last)
  function automatic logic [127:0] dec_round(logic [127:0] s, logic [127:0] k, logic last);
    blk_bytes_t a, t, o;
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] x;
    a = unpack(s);
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*((c + r) % 4)] = a[r + 4*c];
      end
    end
    for (int i = 0; i < 16; i++) begin
      t[i] = INV_SBOX[t[i]];
    end
    x = pack(t) ^ k;
    o = unpack(x);
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = o[4*c]; a1 = o[4*c+1]; a2 = o[4*c+2]; a3 = o[4*c+3];
        o[4*c]   = gm14(a0) ^ gm11(a1) ^ gm13(a2) ^ gm9(a3);
        o[4*c+1] = gm14(a1) ^ gm11(a2) ^ gm13(a3) ^ gm9(a0);
        o[4*c+2] = gm14(a2) ^ gm11(a3) ^ gm13(a0) ^ gm9(a1);
        o[4*c+3] = gm14(a3) ^ gm11(a0) ^ gm13(a1) ^ gm9(a2);
      end
    end
    return pack(o);
  endfunction

endpackage

@@ sv/aes_if.sv @@
// Interfaces: block input channel and result channel.
`timescale 1ns / 1ps
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, kind, block_high, block_low, input ready);
  modport sink   (input valid, kind, block_high, block_low, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

@@ sv/aes_key_exp.sv @@
// Key expansion sequencer: one round-key word per cycle into the round-key store.
`timescale 1ns / 1ps
module aes_key_exp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clr,          // key registers changed
  input  logic [1:0]  sel,          // 0/1/2 = 128/192/256-bit key
  input  logic [63:0] key_word [4],
  output logic [31:0] rk [aes_pkg::RkWords],
  output logic        keys_ready
);

  aes_pkg::kx_state_t state_r, state_nxt;
  logic        ready_r, ready_nxt;
  logic [5:0]  idx_r;
  logic [2:0]  mod_r;
  logic [7:0]  rcon_r;
  logic [31:0] win_r [8];
  logic [31:0] rk_r [aes_pkg::RkWords];

  logic [3:0]  nk;
  logic [2:0]  nk_m1;
  logic [5:0]  last_idx;
  logic [31:0] kw_half, t, w_old, w_new;
  logic        from_key;
  logic [63:0] kw;

  assign nk       = 4'(4 + 2 * sel);
  assign nk_m1    = 3'(3 + 2 * sel);
  assign last_idx = 6'(43 + 8 * sel);
  assign from_key = idx_r < {2'b00, nk};

  // Next word of the schedule
  always_comb begin
    kw      = key_word[idx_r[2:1]];
    kw_half = idx_r[0] ? kw[31:0] : kw[63:32];
    t       = win_r[7];
    if (mod_r == 3'd0) begin
      t = aes_pkg::sub_word({t[23:0], t[31:24]}) ^ {rcon_r, 24'h0};
    end else if (sel == 2'd2 && mod_r == 3'd4) begin
      t = aes_pkg::sub_word(t);
    end
    case (sel)
      2'd0:    w_old = win_r[4];
      2'd1:    w_old = win_r[2];
      default: w_old = win_r[0];
    endcase
    w_new = from_key ? kw_half : (w_old ^ t);
  end

  // Sequencer control
  always_comb begin
    state_nxt = state_r;
    ready_nxt = ready_r;
    case (state_r)
      aes_pkg::KX_IDLE: begin
        if (!ready_r && !clr) state_nxt = aes_pkg::KX_RUN;
      end
      aes_pkg::KX_RUN: begin
        if (clr) begin
          state_nxt = aes_pkg::KX_IDLE;
        end else if (idx_r == last_idx) begin
          state_nxt = aes_pkg::KX_IDLE;
          ready_nxt = 1'b1;
        end
      end
      default: state_nxt = aes_pkg::KX_IDLE;
    endcase
    if (clr) ready_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aes_pkg::KX_IDLE;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
    end
  end

  // Schedule datapath
  always_ff @(posedge clk) begin
    if (state_r == aes_pkg::KX_IDLE) begin
      idx_r  <= '0;
      mod_r  <= '0;
      rcon_r <= 8'h01;
    end else begin
      rk_r[idx_r] <= w_new;
      for (int i = 0; i < 7; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[7] <= w_new;
      idx_r    <= idx_r + 6'd1;
      mod_r    <= (mod_r == nk_m1) ? 3'd0 : mod_r + 3'd1;
      if (!from_key && mod_r == 3'd0) rcon_r <= aes_pkg::xt(rcon_r);
    end
  end

  assign rk         = rk_r;
  assign keys_ready = ready_r;

endmodule

@@ sv/aes_rnd.sv @@
// One pipeline stage: an AES round (forward or inverse), or a pass-through when inactive, plus its stage register.
`timescale 1ns / 1ps
module aes_rnd (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         v_in,
  input  logic         kind_in,
  input  logic [127:0] st_in,
  input  logic [127:0] key_enc,
  input  logic [127:0] key_dec,
  input  logic         active,    // this round is used at the current key length
  input  logic         last,      // final round: no column mix
  input  logic         rdy_dn,
  output logic         rdy_up,
  output logic         v_out,
  output logic         kind_out,
  output logic [127:0] st_out
);

  logic         v_r, kind_r;
  logic [127:0] st_r, st_nxt;

  assign rdy_up = !v_r || rdy_dn;

  always_comb begin
    if (!active) begin
      st_nxt = st_in;
    end else if (kind_in) begin
      st_nxt = aes_pkg::dec_round(st_in, key_dec, last);
    end else begin
      st_nxt = aes_pkg::enc_round(st_in, key_enc, last);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_up) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_up && v_in) begin
      st_r   <= st_nxt;
      kind_r <= kind_in;
    end
  end

  assign v_out    = v_r;
  assign kind_out = kind_r;
  assign st_out   = st_r;

endmodule

@@ sv/aes_block_cipher_core.sv @@
// Top level: AES-128/192/256 ECB cipher, 15-stage round pipeline with APB key registers.
//
//   channel | dir | handshake         | payload
//   in_ch   | in  | valid/ready       | kind, block_high, block_low
//   out_ch  | out | valid/ready       | result_high, result_low
//   APB     | in  | psel/penable      | paddr (8*index), pwdata/prdata 64 bits
//
// One stage per round plus an initial key-add stage; every item passes through
// all stages at every key length, and one item per cycle enters once the round
// keys exist and stage 0 is not stalled. After reset or any key register write the
// schedule is rebuilt one word per cycle, and no item is accepted until it is done.
// Each stage holds while the one after it is full and stalled; no item is lost.
// Reset clears valid bits, key registers and the schedule-ready flag.
`timescale 1ns / 1ps
module aes_block_cipher_core (
  input  logic          clk,
  input  logic          rst_n,
  aes_in_if.sink        in_ch,
  aes_out_if.source     out_ch,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  localparam int NS = aes_pkg::NumStages;

  logic [1:0]  key_len_r;
  logic [63:0] key_word_r [4];
  logic [1:0]  sel;
  logic        wr, clr, keys_ready;
  logic [2:0]  reg_idx;
  logic [31:0] rk [aes_pkg::RkWords];

  logic         v     [NS];
  logic         kd    [NS];
  logic [127:0] st    [NS];
  logic         rdy   [NS+1];

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr      = psel && penable && pwrite;
  assign clr     = wr && (reg_idx <= aes_pkg::REG_KEY_W3);
  assign sel     = (key_len_r == 2'd3) ? 2'd2 : key_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= '0;
      for (int i = 0; i < 4; i++) key_word_r[i] <= '0;
    end else if (wr) begin
      case (reg_idx)
        aes_pkg::REG_KEY_LEN: key_len_r     <= pwdata[1:0];
        aes_pkg::REG_KEY_W0:  key_word_r[0] <= pwdata;
        aes_pkg::REG_KEY_W1:  key_word_r[1] <= pwdata;
        aes_pkg::REG_KEY_W2:  key_word_r[2] <= pwdata;
        aes_pkg::REG_KEY_W3:  key_word_r[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      aes_pkg::REG_KEY_LEN: prdata = {62'h0, key_len_r};
      aes_pkg::REG_KEY_W0:  prdata = key_word_r[0];
      aes_pkg::REG_KEY_W1:  prdata = key_word_r[1];
      aes_pkg::REG_KEY_W2:  prdata = key_word_r[2];
      aes_pkg::REG_KEY_W3:  prdata = key_word_r[3];
      default:              prdata = '0;
    endcase
  end

  aes_key_exp u_kx (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (clr),
    .sel        (sel),
    .key_word   (key_word_r),
    .rk         (rk),
    .keys_ready (keys_ready)
  );

  // Stage 0: initial AddRoundKey
  logic         v0_r, k0_r;
  logic [127:0] st0_r, key0;

  always_comb begin
    if (!in_ch.kind) begin
      key0 = {rk[0], rk[1], rk[2], rk[3]};
    end else begin
      case (sel)
        2'd0:    key0 = {rk[40], rk[41], rk[42], rk[43]};
        2'd1:    key0 = {rk[48], rk[49], rk[50], rk[51]};
        default: key0 = {rk[56], rk[57], rk[58], rk[59]};
      endcase
    end
  end

  assign rdy[0]      = !v0_r || rdy[1];
  assign in_ch.ready = keys_ready && rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (rdy[0]) begin
      v0_r <= in_ch.valid && keys_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      st0_r <= {in_ch.block_high, in_ch.block_low} ^ key0;
      k0_r  <= in_ch.kind;
    end
  end

  assign v[0]  = v0_r;
  assign kd[0] = k0_r;
  assign st[0] = st0_r;

  // Round stages 1..14; decrypt stage j uses round key nr-j
  for (genvar j = 1; j < NS; j++) begin : g_rnd
    localparam int D10 = (10 - j < 0) ? 0 : 10 - j;
    localparam int D12 = (12 - j < 0) ? 0 : 12 - j;
    localparam int D14 = 14 - j;
    logic [127:0] kenc, kdec;
    logic         act, lst;

    assign kenc = {rk[4*j], rk[4*j+1], rk[4*j+2], rk[4*j+3]};
    always_comb begin
      case (sel)
        2'd0: begin
          kdec = {rk[4*D10], rk[4*D10+1], rk[4*D10+2], rk[4*D10+3]};
          act  = (j <= 10);
          lst  = (j == 10);
        end
        2'd1: begin
          kdec = {rk[4*D12], rk[4*D12+1], rk[4*D12+2], rk[4*D12+3]};
          act  = (j <= 12);
          lst  = (j == 12);
        end
        default: begin
          kdec = {rk[4*D14], rk[4*D14+1], rk[4*D14+2], rk[4*D14+3]};
          act  = 1'b1;
          lst  = (j == 14);
        end
      endcase
    end

    aes_rnd u_rnd (
      .clk      (clk),
      .rst_n    (rst_n),
      .v_in     (v[j-1]),
      .kind_in  (kd[j-1]),
      .st_in    (st[j-1]),
      .key_enc  (kenc),
      .key_dec  (kdec),
      .active   (act),
      .last     (lst),
      .rdy_dn   (rdy[j+1]),
      .rdy_up   (rdy[j]),
      .v_out    (v[j]),
      .kind_out (kd[j]),
      .st_out   (st[j])
    );
  end

  // Last stage register drives the result channel
  assign rdy[NS]            = out_ch.ready;
  assign out_ch.valid       = v[NS-1];
  assign out_ch.result_high = st[NS-1][127:64];
  assign out_ch.result_low  = st[NS-1][63:0];

  // Checks
  a_no_accept_unkeyed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> keys_ready)
    else $error("item accepted before round keys were built");

  a_key_write_drops_ready: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> !keys_ready)
    else $error("round keys still marked ready after key write");

  a_stage0_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r && !rdy[1]) |=> (v0_r && $stable(st0_r)))
    else $error("stage 0 item changed while stalled");

  a_first_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v0_r)
    else $error("accepted item missing from stage 0");

endmodule

@@ tb/sv/testbench.sv @@
// Testbench: AES block cipher core, checked against an in-bench cipher predictor.
`timescale 1ns / 1ps
module testbench;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  aes_in_if  blk_in ();
  aes_out_if blk_out ();

  aes_block_cipher_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (blk_in.sink),
    .out_ch  (blk_out.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  localparam int CycleLimit = 2000000;
  localparam int DrainCycles = 40;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } cipher_op_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  // predictor copy of the key registers and schedule
  logic [1:0]  key_len_q;
  logic [63:0] key_q [4];
  logic [31:0] sched [60];
  logic        sched_ok;
  int          rounds;

  block_t      expected_blocks [$];
  int          fail_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] gf_double(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_double(a);
    end
    return p;
  endfunction

  function automatic logic [31:0] sbox_word(logic [31:0] w);
    return {aes_pkg::SBOX[w[31:24]], aes_pkg::SBOX[w[23:16]],
            aes_pkg::SBOX[w[15:8]], aes_pkg::SBOX[w[7:0]]};
  endfunction

  // key schedule from the current key registers
  task automatic build_schedule();
    int nk;
    int sel;
    logic [7:0] rc;
    logic [31:0] t;
    sel = (key_len_q > 2) ? 2 : int'(key_len_q);
    nk = 4 + 2 * sel;
    rounds = nk + 6;
    rc = 8'h01;
    for (int i = 0; i < nk; i++) begin
      sched[i] = (i % 2 == 0) ? key_q[i / 2][63:32] : key_q[i / 2][31:0];
    end
    for (int i = nk; i < 4 * (rounds + 1); i++) begin
      t = sched[i - 1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_double(rc);
      end else if (nk == 8 && i % nk == 4) begin
        t = sbox_word(t);
      end
      sched[i] = sched[i - nk] ^ t;
    end
    sched_ok = 1'b1;
  endtask

  function automatic void mix_key(ref logic [7:0] s [16], input int r);
    logic [31:0] w;
    for (int i = 0; i < 16; i++) begin
      w = sched[4 * r + i / 4];
      s[i] ^= w[31 - 8 * (i % 4) -: 8];
    end
  endfunction

  function automatic void mix_cols(ref logic [7:0] s [16], input bit inv);
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
      if (!inv) begin
        s[4*c]   = gf_mul(a0, 2) ^ gf_mul(a1, 3) ^ a2 ^ a3;
        s[4*c+1] = gf_mul(a1, 2) ^ gf_mul(a2, 3) ^ a3 ^ a0;
        s[4*c+2] = gf_mul(a2, 2) ^ gf_mul(a3, 3) ^ a0 ^ a1;
        s[4*c+3] = gf_mul(a3, 2) ^ gf_mul(a0, 3) ^ a1 ^ a2;
      end else begin
        s[4*c]   = gf_mul(a0, 14) ^ gf_mul(a1, 11) ^ gf_mul(a2, 13) ^ gf_mul(a3, 9);
        s[4*c+1] = gf_mul(a1, 14) ^ gf_mul(a2, 11) ^ gf_mul(a3, 13) ^ gf_mul(a0, 9);
        s[4*c+2] = gf_mul(a2, 14) ^ gf_mul(a3, 11) ^ gf_mul(a0, 13) ^ gf_mul(a1, 9);
        s[4*c+3] = gf_mul(a3, 14) ^ gf_mul(a0, 11) ^ gf_mul(a1, 13) ^ gf_mul(a2, 9);
      end
    end
  endfunction

  // full cipher or inverse cipher on one block
  task automatic predict_block(input cipher_op_t op, input block_t blk, output block_t res);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] inv_tbl [256];
    logic [127:0] flat;
    if (!sched_ok) build_schedule();
    flat = {blk.hi, blk.lo};
    for (int i = 0; i < 16; i++) s[i] = flat[127 - 8 * i -: 8];
    if (op == OP_ENCRYPT) begin
      mix_key(s, 0);
      for (int r = 1; r <= rounds; r++) begin
        for (int i = 0; i < 16; i++) t[i] = aes_pkg::SBOX[s[i]];
        for (int c = 0; c < 4; c++)
          for (int w = 0; w < 4; w++) s[w + 4 * c] = t[w + 4 * ((c + w) % 4)];
        if (r != rounds) mix_cols(s, 1'b0);
        mix_key(s, r);
      end
    end else begin
      for (int i = 0; i < 256; i++) inv_tbl[aes_pkg::SBOX[i]] = 8'(i);
      mix_key(s, rounds);
      for (int r = rounds - 1; r >= 0; r--) begin
        for (int c = 0; c < 4; c++)
          for (int w = 0; w < 4; w++) t[w + 4 * ((c + w) % 4)] = s[w + 4 * c];
        for (int i = 0; i < 16; i++) s[i] = inv_tbl[t[i]];
        mix_key(s, r);
        if (r != 0) mix_cols(s, 1'b1);
      end
    end
    for (int i = 0; i < 16; i++) flat[127 - 8 * i -: 8] = s[i];
    res.hi = flat[127:64];
    res.lo = flat[63:0];
  endtask

  // APB write: setup then access, then a read back
  task automatic write_reg(input aes_pkg::reg_idx_t idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 6'(8 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == aes_pkg::REG_KEY_LEN) begin
      if (prdata[1:0] !== value[1:0])
        $error("readback %s: expected %h actual %h", idx.name(), value[1:0], prdata[1:0]);
    end else if (prdata !== value) begin
      $error("readback %s: expected %h actual %h", idx.name(), value, prdata);
    end
    if (idx == aes_pkg::REG_KEY_LEN) begin
      if (prdata[1:0] !== value[1:0]) fail_count++;
    end else if (prdata !== value) fail_count++;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == aes_pkg::REG_KEY_LEN) key_len_q = value[1:0];
    else key_q[int'(idx) - 1] = value;
    sched_ok = 1'b0;
    @(posedge clk);
  endtask

  // drive one item and log its expected result
  task automatic send_block(input cipher_op_t op, input block_t blk);
    block_t res;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      blk_in.valid <= 1'b0;
      @(posedge clk);
    end
    blk_in.valid      <= 1'b1;
    blk_in.kind       <= op;
    blk_in.block_high <= blk.hi;
    blk_in.block_low  <= blk.lo;
    @(posedge clk);
    while (!blk_in.ready) @(posedge clk);
    predict_block(op, blk, res);
    expected_blocks = {expected_blocks, res};
  endtask

  task automatic wait_drained();
    blk_in.valid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    block_t exp_blk;
    if (rst_n && blk_out.valid && blk_out.ready) begin
      if (expected_blocks.size() == 0) begin
        $error("unexpected result %h %h", blk_out.result_high, blk_out.result_low);
        fail_count++;
      end else begin
        exp_blk = expected_blocks.pop_front();
        if (blk_out.result_high !== exp_blk.hi) begin
          $error("result_high: expected %h actual %h", exp_blk.hi, blk_out.result_high);
          fail_count++;
        end
        if (blk_out.result_low !== exp_blk.lo) begin
          $error("result_low: expected %h actual %h", exp_blk.lo, blk_out.result_low);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    blk_out.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  function automatic block_t rand_block();
    block_t b;
    b.hi = {$urandom, $urandom};
    b.lo = {$urandom, $urandom};
    return b;
  endfunction

  // standard example inputs and reset-key blocks, checked against the predictor
  task automatic test_directed();
    block_t pt;
    pt = '{64'h0011223344556677, 64'h8899aabbccddeeff};
    // reset key, all-zero and all-one blocks
    send_block(OP_ENCRYPT, '{64'h0, 64'h0});
    send_block(OP_DECRYPT, '{64'hffffffffffffffff, 64'hffffffffffffffff});
    wait_drained();
    write_reg(aes_pkg::REG_KEY_W0, 64'h0001020304050607);
    write_reg(aes_pkg::REG_KEY_W1, 64'h08090a0b0c0d0e0f);
    write_reg(aes_pkg::REG_KEY_W2, 64'h1011121314151617);
    write_reg(aes_pkg::REG_KEY_W3, 64'h18191a1b1c1d1e1f);
    for (int len = 0; len < 4; len++) begin
      write_reg(aes_pkg::REG_KEY_LEN, 64'(len));
      send_block(OP_ENCRYPT, pt);
      send_block(OP_DECRYPT, pt);
      send_block(OP_ENCRYPT, '{64'hffffffffffffffff, 64'h0});
      wait_drained();
    end
    // extreme keys
    write_reg(aes_pkg::REG_KEY_W0, 64'hffffffffffffffff);
    write_reg(aes_pkg::REG_KEY_W1, 64'hffffffffffffffff);
    write_reg(aes_pkg::REG_KEY_W2, 64'hffffffffffffffff);
    write_reg(aes_pkg::REG_KEY_W3, 64'hffffffffffffffff);
    send_block(OP_ENCRYPT, '{64'h0, 64'hffffffffffffffff});
    send_block(OP_DECRYPT, pt);
    wait_drained();
  endtask

  // random keys, key lengths and blocks under one idle and stall profile
  task automatic test_random(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < count; k++) begin
      if (k % 45 == 0) begin
        wait_drained();
        write_reg(aes_pkg::REG_KEY_LEN, 64'($urandom_range(3)));
        for (int w = 0; w < 4; w++)
          if ($urandom_range(3) != 0)
            write_reg(aes_pkg::reg_idx_t'(w + 1), {$urandom, $urandom});
      end
      send_block(cipher_op_t'($urandom_range(1)), rand_block());
      if (k == count / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    fail_count     = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sched_ok       = 1'b0;
    key_len_q      = 2'd0;
    rounds         = 10;
    for (int i = 0; i < 4; i++) key_q[i] = 64'h0;
    rst_n             <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    blk_in.valid      <= 1'b0;
    blk_in.kind       <= 1'b0;
    blk_in.block_high <= '0;
    blk_in.block_low  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(0, 0, 360);
    test_random(78, 0, 330);
    test_random(0, 78, 330);
    test_random(22, 22, 330);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
